>>> rtl/core/bcc_pkg.sv
// Package for the button click classifier: modes, action codes, register
// indexes, result entry type and shared helpers.
// No dependencies; every other file of the block imports it.
package bcc_pkg;

    // Widths of the payload fields and registers.
    localparam int TICKS_W  = 16;
    localparam int ACTION_W = 3;
    localparam int CLICKS_W = 3;
    localparam int CFG_IDX_W = 2;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register reset values.
    localparam logic               ACTIVE_LEVEL_RST = 1'b0;
    localparam logic [TICKS_W-1:0] DEBOUNCE_RST     = 16'd20;
    localparam logic [TICKS_W-1:0] LONG_PRESS_RST   = 16'd800;
    localparam logic [TICKS_W-1:0] MULTI_CLICK_RST  = 16'd300;

    // Saturation value of the click counter.
    localparam logic [CLICKS_W-1:0] CLICKS_MAX = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LEVEL = 2'd0,
        CFG_DEBOUNCE     = 2'd1,
        CFG_LONG_PRESS   = 2'd2,
        CFG_MULTI_CLICK  = 2'd3
    } cfg_reg_t;

    // Operating modes of the classifier.
    typedef enum logic [2:0] {
        MODE_IDLE         = 3'd0,
        MODE_DEBOUNCE     = 3'd1,
        MODE_WAIT_RELEASE = 3'd2,
        MODE_WAIT_NEXT    = 3'd3,
        MODE_HOLD         = 3'd4
    } mode_t;

    // Reported actions.
    typedef enum logic [ACTION_W-1:0] {
        ACT_SINGLE = 3'd0,
        ACT_DOUBLE = 3'd1,
        ACT_TRIPLE = 3'd2,
        ACT_LONG   = 3'd3,
        ACT_REPEAT = 3'd4
    } action_t;

    // One queued result beat.
    typedef struct packed {
        action_t action;
        logic    last;
    } result_t;

    // A programmed duration of zero counts as one tick.
    function automatic logic [TICKS_W-1:0] arm_ticks(input logic [TICKS_W-1:0] ticks);
        logic [TICKS_W-1:0] armed;
        armed = (ticks == '0) ? TICKS_W'(1) : ticks;
        return armed;
    endfunction

endpackage

>>> rtl/core/bcc_if.sv
// Channel interfaces of the button click classifier: the sample channel
// and the result channel, each with valid, ready and payload.
// Depends on bcc_pkg for the field widths.
interface bcc_in_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic tick;

    modport source (output valid, output pin_level, output tick, input ready);
    modport sink   (input valid, input pin_level, input tick, output ready);
endinterface

interface bcc_out_if
    import bcc_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                last;

    modport source (output valid, output action, output last, input ready);
    modport sink   (input valid, input action, input last, output ready);
endinterface

>>> rtl/core/button_click_classifier_unit.sv
// Top level of the button click classifier: mode logic, tick timer, click
// counter and a small result queue between the sample and result channels.
// Depends on bcc_pkg and the channel interfaces in bcc_if.sv.
//
//  channel   direction  beat payload             notes
//  in_ch     sink       pin_level, tick          one sample per beat
//  out_ch    source     action, last             zero to two beats per sample
//  cfg_*     write      cfg_index, cfg_data      no wait, no read-back
//
// A sample is processed in the cycle it is accepted; its results enter a
// four-entry queue and can leave on the next cycle, one beat per cycle if ready.
// Samples are taken every cycle while the queue has room for two results,
// so the rate is one sample per cycle unless the result side stalls.
// Reset clears mode, timer, click count, queue pointers; presets the registers.
module button_click_classifier_unit
    import bcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bcc_in_if.sink               in_ch,
    bcc_out_if.source            out_ch,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICKS_W-1:0]   cfg_data
);

    // Configuration registers.
    logic               active_level_reg;
    logic [TICKS_W-1:0] debounce_reg;
    logic [TICKS_W-1:0] long_press_reg;
    logic [TICKS_W-1:0] multi_click_reg;

    // Classifier state.
    mode_t               mode_reg, mode_next;
    logic [TICKS_W-1:0]  timer_reg, timer_next;
    logic [CLICKS_W-1:0] clicks_reg, clicks_next;
    logic                prev_level_reg;

    // Intermediate state after the level edge has been handled.
    mode_t               edge_mode;
    logic [TICKS_W-1:0]  edge_timer;
    logic [CLICKS_W-1:0] edge_clicks;
    logic [TICKS_W-1:0]  timer_dec;
    logic                timeout;

    // Results caused by the current sample.
    logic [1:0] emit_count;
    action_t    emit_first;

    // Result queue.
    result_t           queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              accept;
    logic              pop;

    assign in_ch.ready = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign accept      = in_ch.valid && in_ch.ready;
    assign pop         = out_ch.valid && out_ch.ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg <= ACTIVE_LEVEL_RST;
            debounce_reg     <= DEBOUNCE_RST;
            long_press_reg   <= LONG_PRESS_RST;
            multi_click_reg  <= MULTI_CLICK_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ACTIVE_LEVEL: active_level_reg <= cfg_data[0];
                CFG_DEBOUNCE:     debounce_reg     <= cfg_data;
                CFG_LONG_PRESS:   long_press_reg   <= cfg_data;
                CFG_MULTI_CLICK:  multi_click_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Level edge: a change to the active level is a press, else a release.
    always_comb
    begin
        edge_mode   = mode_reg;
        edge_timer  = timer_reg;
        edge_clicks = clicks_reg;
        if (in_ch.pin_level != prev_level_reg)
        begin
            if (in_ch.pin_level == active_level_reg)
            begin
                if (mode_reg == MODE_IDLE || mode_reg == MODE_WAIT_NEXT)
                begin
                    edge_mode  = MODE_DEBOUNCE;
                    edge_timer = arm_ticks(debounce_reg);
                end
            end
            else if (mode_reg == MODE_WAIT_RELEASE)
            begin
                if (clicks_reg != CLICKS_MAX)
                begin
                    edge_clicks = clicks_reg + CLICKS_W'(1);
                end
                edge_mode  = MODE_WAIT_NEXT;
                edge_timer = arm_ticks(multi_click_reg);
            end
            else if (mode_reg == MODE_HOLD)
            begin
                edge_mode   = MODE_IDLE;
                edge_timer  = '0;
                edge_clicks = '0;
            end
        end
    end

    // The tick counts a running timer down; reaching zero is a timeout.
    assign timer_dec = edge_timer - TICKS_W'(1);
    assign timeout   = in_ch.tick && (edge_timer != '0) && (timer_dec == '0);

    // Next state after the tick.
    always_comb
    begin
        mode_next   = edge_mode;
        timer_next  = edge_timer;
        clicks_next = edge_clicks;
        if (in_ch.tick && edge_timer != '0)
        begin
            timer_next = timer_dec;
        end
        if (timeout)
        begin
            unique case (edge_mode)
                MODE_DEBOUNCE:
                begin
                    if (in_ch.pin_level == active_level_reg)
                    begin
                        mode_next  = MODE_WAIT_RELEASE;
                        timer_next = arm_ticks(long_press_reg);
                    end
                    else
                    begin
                        mode_next   = MODE_IDLE;
                        clicks_next = '0;
                    end
                end
                MODE_WAIT_RELEASE:
                begin
                    mode_next  = MODE_HOLD;
                    timer_next = arm_ticks(multi_click_reg);
                end
                MODE_WAIT_NEXT:
                begin
                    mode_next   = MODE_IDLE;
                    clicks_next = '0;
                end
                MODE_HOLD:
                begin
                    timer_next = arm_ticks(multi_click_reg);
                end
                default: ;
            endcase
        end
    end

    // Results of the timeout.
    always_comb
    begin
        emit_count = 2'd0;
        emit_first = ACT_SINGLE;
        if (timeout)
        begin
            unique case (edge_mode)
                MODE_WAIT_RELEASE:
                begin
                    emit_count = 2'd2;
                    emit_first = ACT_LONG;
                end
                MODE_WAIT_NEXT:
                begin
                    case (edge_clicks)
                        3'd1:
                        begin
                            emit_count = 2'd1;
                            emit_first = ACT_SINGLE;
                        end
                        3'd2:
                        begin
                            emit_count = 2'd1;
                            emit_first = ACT_DOUBLE;
                        end
                        3'd3:
                        begin
                            emit_count = 2'd1;
                            emit_first = ACT_TRIPLE;
                        end
                        default: ;
                    endcase
                end
                MODE_HOLD:
                begin
                    emit_count = 2'd1;
                    emit_first = ACT_REPEAT;
                end
                default: ;
            endcase
        end
    end

    // Classifier state registers, updated on each accepted sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            timer_reg      <= '0;
            clicks_reg     <= '0;
            prev_level_reg <= ~ACTIVE_LEVEL_RST;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            timer_reg      <= timer_next;
            clicks_reg     <= clicks_next;
            prev_level_reg <= in_ch.pin_level;
        end
    end

    // Result queue payload; the second of a pair is always the repeat.
    always_ff @(posedge clk)
    begin
        if (accept && emit_count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= '{action: emit_first, last: (emit_count == 2'd1)};
            if (emit_count == 2'd2)
            begin
                queue_reg[wr_ptr_reg + QPTR_W'(1)] <= '{action: ACT_REPEAT, last: 1'b1};
            end
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(emit_count);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + (accept ? QCNT_W'(emit_count) : QCNT_W'(0))
                         - (pop ? QCNT_W'(1) : QCNT_W'(0));
        end
    end

    // Result channel.
    assign out_ch.valid  = (count_reg != '0);
    assign out_ch.action = queue_reg[rd_ptr_reg].action;
    assign out_ch.last   = queue_reg[rd_ptr_reg].last;

endmodule

>>> tb/sv/tb_button_click_classifier_unit.sv
// Self-checking bench for the button click classifier: directed table and random
// press gestures, scored against an in-bench classifier or typed table results.
// Depends on bcc_pkg, the channel interfaces in bcc_if.sv and the block's top level.
module tb_button_click_classifier_unit
    import bcc_pkg::*;
;

    localparam int QUIET_LIMIT   = 2000;
    localparam int LATENCY_PAD   = 4;
    localparam int RANDOM_ITEMS  = 360;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_TYPED,
        ROW_CONFIG
    } row_kind_t;

    // One line of the directed table: a sample, a sample with its results
    // written out, or a full register setting.
    typedef struct packed {
        row_kind_t          kind;
        logic               pin;
        logic               tick;
        logic [1:0]         n_typed;
        action_t            first_act;
        action_t            second_act;
        logic               active;
        logic [TICKS_W-1:0] debounce;
        logic [TICKS_W-1:0] long_press;
        logic [TICKS_W-1:0] multi_click;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICKS_W-1:0]   cfg_data;

    bcc_in_if  in_ch();
    bcc_out_if out_ch();

    button_click_classifier_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // Classifier state and register copies kept by the bench.
    mode_t              press_mode   = MODE_IDLE;
    logic [TICKS_W-1:0] ticks_left   = '0;
    logic [CLICKS_W-1:0] click_total = '0;
    logic               last_level   = ~ACTIVE_LEVEL_RST;
    logic               lvl_active   = ACTIVE_LEVEL_RST;
    logic [TICKS_W-1:0] debounce_len = DEBOUNCE_RST;
    logic [TICKS_W-1:0] long_len     = LONG_PRESS_RST;
    logic [TICKS_W-1:0] window_len   = MULTI_CLICK_RST;

    result_t pending_actions[$];
    int      mismatches      = 0;
    int      samples_sent    = 0;
    int      predicted_beats = 0;
    int      settings_loaded = 0;
    int      seen_by_action[5];
    bit      tx_calm = 1'b0;
    bit      rx_calm = 1'b0;
    int      quiet_cycles = 0;

    // A programmed duration of zero runs for one tick.
    function automatic logic [TICKS_W-1:0] armed_value(input logic [TICKS_W-1:0] ticks);
        return (ticks == '0) ? TICKS_W'(1) : ticks;
    endfunction

    function automatic void queue_action(input action_t act, input bit is_last);
        result_t beat;
        beat.action = act;
        beat.last   = is_last;
        pending_actions.push_back(beat);
        predicted_beats++;
    endfunction

    // Advance the classifier by one sample and queue the actions it reports.
    function automatic int classify_sample(input logic pin, input logic tk);
        int n;
        n = 0;

        // A level change is judged first: press or release.
        if (pin != last_level) begin
            if (pin == lvl_active) begin
                if (press_mode == MODE_IDLE || press_mode == MODE_WAIT_NEXT) begin
                    press_mode = MODE_DEBOUNCE;
                    ticks_left = armed_value(debounce_len);
                end
            end else if (press_mode == MODE_WAIT_RELEASE) begin
                if (click_total != CLICKS_MAX)
                    click_total = click_total + 3'd1;
                press_mode = MODE_WAIT_NEXT;
                ticks_left = armed_value(window_len);
            end else if (press_mode == MODE_HOLD) begin
                ticks_left  = '0;
                press_mode  = MODE_IDLE;
                click_total = '0;
            end
            last_level = pin;
        end

        // Then the tick: count down a running timer and act on expiry.
        if (tk && ticks_left != '0) begin
            ticks_left = ticks_left - 16'd1;
            if (ticks_left == '0) begin
                case (press_mode)
                    MODE_DEBOUNCE: begin
                        if (pin == lvl_active) begin
                            press_mode = MODE_WAIT_RELEASE;
                            ticks_left = armed_value(long_len);
                        end else begin
                            press_mode  = MODE_IDLE;
                            click_total = '0;
                        end
                    end
                    MODE_WAIT_RELEASE: begin
                        queue_action(ACT_LONG, 1'b0);
                        queue_action(ACT_REPEAT, 1'b1);
                        n = 2;
                        press_mode = MODE_HOLD;
                        ticks_left = armed_value(window_len);
                    end
                    MODE_WAIT_NEXT: begin
                        if (click_total == 3'd1) begin
                            queue_action(ACT_SINGLE, 1'b1);
                            n = 1;
                        end else if (click_total == 3'd2) begin
                            queue_action(ACT_DOUBLE, 1'b1);
                            n = 1;
                        end else if (click_total == 3'd3) begin
                            queue_action(ACT_TRIPLE, 1'b1);
                            n = 1;
                        end
                        press_mode  = MODE_IDLE;
                        click_total = '0;
                    end
                    MODE_HOLD: begin
                        queue_action(ACT_REPEAT, 1'b1);
                        n = 1;
                        ticks_left = armed_value(window_len);
                    end
                    default: ;
                endcase
            end
        end
        return n;
    endfunction

    function automatic plan_row_t sample_row(input logic pin, input logic tk);
        plan_row_t row;
        row      = '0;
        row.kind = ROW_SAMPLE;
        row.pin  = pin;
        row.tick = tk;
        return row;
    endfunction

    function automatic plan_row_t typed_row(input logic pin, input logic tk, input int n = 0,
                                            input action_t a0 = ACT_SINGLE,
                                            input action_t a1 = ACT_SINGLE);
        plan_row_t row;
        row            = sample_row(pin, tk);
        row.kind       = ROW_TYPED;
        row.n_typed    = 2'(n);
        row.first_act  = a0;
        row.second_act = a1;
        return row;
    endfunction

    function automatic plan_row_t config_row(input logic al, input logic [TICKS_W-1:0] db,
                                             input logic [TICKS_W-1:0] lp,
                                             input logic [TICKS_W-1:0] mc);
        plan_row_t row;
        row             = '0;
        row.kind        = ROW_CONFIG;
        row.active      = al;
        row.debounce    = db;
        row.long_press  = lp;
        row.multi_click = mc;
        return row;
    endfunction

    // Send one sample beat, after a random gap unless tx_calm, and predict its results.
    task automatic send_sample(input logic pin, input logic tk, output int made);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(18, 0);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.pin_level <= pin;
        in_ch.tick      <= tk;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        samples_sent++;
        made = classify_sample(pin, tk);
    endtask

    // Hold one level for a number of ticks, with tickless samples mixed in.
    task automatic dwell(input logic pin, input int ticks);
        int   counted;
        int   made;
        logic tk;
        counted = 0;
        while (counted < ticks) begin
            tk = ($urandom_range(3, 0) != 0);
            send_sample(pin, tk, made);
            if (tk)
                counted++;
        end
    endtask

    // Stop sending and wait until every predicted beat has come out.
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    // Write all four registers back to back while the block is quiet.
    task automatic load_settings(input logic al, input logic [TICKS_W-1:0] db,
                                 input logic [TICKS_W-1:0] lp, input logic [TICKS_W-1:0] mc);
        cfg_reg_t r;
        settle_block();
        r = r.first();
        repeat (r.num()) begin
            cfg_write_en <= 1'b1;
            cfg_index    <= r;
            case (r)
                CFG_ACTIVE_LEVEL: cfg_data <= {{(TICKS_W-1){1'b0}}, al};
                CFG_DEBOUNCE:     cfg_data <= db;
                CFG_LONG_PRESS:   cfg_data <= lp;
                default:          cfg_data <= mc;
            endcase
            @(posedge clk);
            r = r.next();
        end
        cfg_write_en <= 1'b0;
        lvl_active   = al;
        debounce_len = db;
        long_len     = lp;
        window_len   = mc;
        settings_loaded++;
    endtask

    // Result side: random stalls unless calm, each beat against the oldest prediction.
    initial begin : result_checker
        int      stall;
        result_t want;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(18, 0);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (out_ch.valid !== 1'b1) @(posedge clk);
            if (out_ch.action <= ACT_REPEAT)
                seen_by_action[out_ch.action]++;
            if (pending_actions.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat: action %0d last %0b", $time,
                         out_ch.action, out_ch.last);
            end else begin
                want = pending_actions.pop_front();
                if (out_ch.action !== want.action || out_ch.last !== want.last) begin
                    mismatches++;
                    $display("%0t: expected action %s last %0b, got action %0d last %0b",
                             $time, want.action.name(), want.last, out_ch.action, out_ch.last);
                end
            end
        end
    end

    // Watchdog: end the run when no beat or register write happens for too long.
    always @(posedge clk) begin
        if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || cfg_write_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d beats still awaited", $time,
                     quiet_cycles, pending_actions.size());
            $display("button_click_classifier_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        plan_row_t plan[$];
        result_t   beat;
        int        made;
        int        item_base;
        int        phase_end;
        int        pick;
        int        clicks;
        int        db_t;
        int        lp_t;
        int        mc_t;
        logic      lvl;

        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.pin_level = 1'b0;
        in_ch.tick      = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_index       = CFG_ACTIVE_LEVEL;
        cfg_data        = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset: the pin rests at the idle level and ticks find no timer.
        plan.push_back(typed_row(1'b1, 1'b1));
        plan.push_back(typed_row(1'b1, 1'b0));
        // Zero durations all act as one tick: long press, repeats, release.
        plan.push_back(config_row(1'b0, 16'd0, 16'd0, 16'd0));
        plan.push_back(typed_row(1'b0, 1'b1));
        plan.push_back(typed_row(1'b0, 1'b1, 2, ACT_LONG, ACT_REPEAT));
        plan.push_back(typed_row(1'b0, 1'b1, 1, ACT_REPEAT));
        plan.push_back(typed_row(1'b1, 1'b0));
        // Single, double and triple click.
        plan.push_back(typed_row(1'b0, 1'b1));
        plan.push_back(typed_row(1'b1, 1'b1, 1, ACT_SINGLE));
        plan.push_back(sample_row(1'b0, 1'b1));
        plan.push_back(sample_row(1'b1, 1'b0));
        plan.push_back(sample_row(1'b0, 1'b1));
        plan.push_back(typed_row(1'b1, 1'b1, 1, ACT_DOUBLE));
        plan.push_back(sample_row(1'b0, 1'b1));
        plan.push_back(sample_row(1'b1, 1'b0));
        plan.push_back(sample_row(1'b0, 1'b1));
        plan.push_back(sample_row(1'b1, 1'b0));
        plan.push_back(sample_row(1'b0, 1'b1));
        plan.push_back(typed_row(1'b1, 1'b1, 1, ACT_TRIPLE));
        // Flip the active level with the pin left where it was; then a stray
        // release, a release during debounce and a debounce that fails.
        plan.push_back(config_row(1'b1, 16'd2, 16'd0, 16'd0));
        plan.push_back(typed_row(1'b1, 1'b1));
        plan.push_back(typed_row(1'b0, 1'b1));
        plan.push_back(typed_row(1'b1, 1'b0));
        plan.push_back(typed_row(1'b0, 1'b1));
        plan.push_back(typed_row(1'b0, 1'b1));

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CONFIG: load_settings(plan[i].active, plan[i].debounce,
                                          plan[i].long_press, plan[i].multi_click);
                ROW_SAMPLE: send_sample(plan[i].pin, plan[i].tick, made);
                default: begin
                    // The typed results replace what the classifier predicted.
                    send_sample(plan[i].pin, plan[i].tick, made);
                    repeat (made) void'(pending_actions.pop_back());
                    for (int k = 0; k < int'(plan[i].n_typed); k++) begin
                        beat.action = (k == 0) ? plan[i].first_act : plan[i].second_act;
                        beat.last   = (k == int'(plan[i].n_typed) - 1);
                        pending_actions.push_back(beat);
                    end
                end
            endcase
        end

        // Random gestures under short random settings.
        item_base = samples_sent;
        phase_end = samples_sent;
        while ((samples_sent - item_base) < RANDOM_ITEMS) begin
            if (samples_sent >= phase_end) begin
                load_settings(1'($urandom_range(1, 0)), 16'($urandom_range(5, 0)),
                              16'($urandom_range(10, 0)), 16'($urandom_range(8, 0)));
                tx_calm   = ($urandom_range(3, 0) == 0);
                rx_calm   = ($urandom_range(3, 0) == 0);
                phase_end = samples_sent + $urandom_range(120, 40);
            end
            lvl  = lvl_active;
            db_t = int'(armed_value(debounce_len));
            lp_t = int'(armed_value(long_len));
            mc_t = int'(armed_value(window_len));
            pick = $urandom_range(9, 0);
            if (pick == 0) begin
                // Noise: any level, any tick.
                repeat ($urandom_range(4, 1))
                    send_sample(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), made);
            end else if (pick <= 2) begin
                // Long hold with a few repeats.
                send_sample(lvl, 1'($urandom_range(1, 0)), made);
                dwell(lvl, db_t + lp_t + $urandom_range(3 * mc_t, 0));
                send_sample(!lvl, 1'($urandom_range(1, 0)), made);
                dwell(!lvl, $urandom_range(3, 0));
            end else begin
                // A burst of clicks; sometimes enough to saturate the count.
                clicks = ($urandom_range(3, 0) == 0) ? $urandom_range(9, 4)
                                                     : $urandom_range(3, 1);
                for (int c = 1; c <= clicks; c++) begin
                    send_sample(lvl, 1'($urandom_range(1, 0)), made);
                    dwell(lvl, $urandom_range(db_t + lp_t - 1, db_t));
                    send_sample(!lvl, 1'($urandom_range(1, 0)), made);
                    if (c < clicks)
                        dwell(!lvl, $urandom_range(mc_t - 1, 0));
                    else
                        dwell(!lvl, mc_t + $urandom_range(2, 0));
                end
            end
        end

        settle_block();
        repeat (8) @(posedge clk);

        $display("%0d samples sent, %0d result beats predicted, under %0d register settings",
                 samples_sent, predicted_beats, settings_loaded);
        $display("beats seen: single %0d, double %0d, triple %0d, long %0d, repeat %0d",
                 seen_by_action[ACT_SINGLE], seen_by_action[ACT_DOUBLE],
                 seen_by_action[ACT_TRIPLE], seen_by_action[ACT_LONG],
                 seen_by_action[ACT_REPEAT]);
        if (mismatches == 0 && pending_actions.size() == 0)
            $display("button_click_classifier_unit: match");
        else
            $display("button_click_classifier_unit: mismatch");
        $finish;
    end

endmodule
